// File: src/ibalc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibalc_pkg: shared types and constants for the indexed block allocator
// Sizes, status and register codes, the file table row and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ibalc_pkg;

  localparam int MAX_BLOCKS      = 256;
  localparam int FILE_SLOTS      = 128;
  localparam int BLOCKS_PER_FILE = 10;

  localparam int BLK_W   = $clog2(MAX_BLOCKS);          // block number
  localparam int ADDR_W  = $clog2(FILE_SLOTS);          // table address
  localparam int FT_W    = $clog2(FILE_SLOTS + 1);      // file count
  localparam int SLOT_W  = $clog2(BLOCKS_PER_FILE + 1); // slot counter
  localparam int SLOTS   = BLOCKS_PER_FILE + 1;         // index + data
  localparam int TB_W    = 9;
  localparam int BS_W    = 16;
  localparam int BYTES_W = 20;
  localparam int KEY_W   = 64;
  localparam int CNT_W   = 4;

  localparam logic [2:0] ST_GRANT      = 3'd0;
  localparam logic [2:0] ST_DELETED    = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
  localparam logic [2:0] ST_NO_INDEX   = 3'd3;
  localparam logic [2:0] ST_MEM_FULL   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd5;
  localparam logic [2:0] ST_TABLE_FULL = 3'd6;

  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic REG_BLK_SPAN  = 1'b0;
  localparam logic REG_BLK_BYTES = 1'b1;

  localparam logic [TB_W-1:0] TB_RESET   = 9'd256;
  localparam logic [BS_W-1:0] BS_RESET   = 16'd512;
  localparam logic [15:0]     LFSR_SEED  = 16'hACE1;
  localparam logic [15:0]     LFSR_TAPS  = 16'hB400;

  typedef logic [BLK_W-1:0] blk_t;

  typedef struct packed {
    logic [KEY_W-1:0]                 key;
    blk_t                             idx_blk;
    blk_t [BLOCKS_PER_FILE-1:0]       data;
    logic [CNT_W-1:0]                 count;
  } tbl_row_t;

  typedef struct packed {
    logic       load_req;
    logic       div_size;
    logic       div_probe;
    logic       need_load;
    logic       probe_clr;
    logic       probe_inc;
    logic       take;
    logic       alloc_clr;
    logic       j_clr;
    logic       j_inc;
    logic       rb_free;
    logic       del_free;
    logic       tbl_new;
    logic       ft_dec;
    logic       ptr_clr;
    logic       ptr_inc;
    logic       rd_ptr;
    logic       rd_next;
    logic       wr_shift;
    logic       emit;
    logic       emit_grant;
    logic [2:0] emit_code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic too_large;
    logic table_full;
    logic ft_zero;
    logic pos_free;
    logic probe_last;
    logic alloc_done;
    logic alloc_empty;
    logic rb_done;
    logic key_match;
    logic search_last;
    logic dfree_done;
    logic shift_done;
    logic emit_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: src/ibalc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibalc_div: multicycle unsigned divider
// Restoring division, four quotient bits per cycle; quotient and remainder
// are valid in the cycle that done pulses and hold until the next start.
// ----------------------------------------------------------------------------
module ibalc_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ibalc_pkg::BYTES_W-1:0] dividend,
  input  wire logic [ibalc_pkg::BS_W-1:0]    divisor,
  output logic                             done,
  output logic [ibalc_pkg::BYTES_W-1:0]    quo,
  output logic [ibalc_pkg::BS_W-1:0]       rem
);
  import ibalc_pkg::*;

  localparam int STEPS  = 4;
  localparam int CYCLES = BYTES_W / STEPS;
  localparam int CW     = $clog2(CYCLES);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [BS_W-1:0]   dvs;
  logic [BYTES_W-1:0] q_step;
  logic [BS_W-1:0]   r_step;

  always_comb begin
    logic [BS_W:0]      rr;
    logic [BYTES_W-1:0] q;
    logic [BS_W-1:0]    r;
    logic               ge;
    q = quo;
    r = rem;
    for (int i = 0; i < STEPS; i++) begin
      rr = {r, q[BYTES_W-1]};
      ge = (rr >= {1'b0, dvs});
      rr = ge ? (rr - {1'b0, dvs}) : rr;
      r  = rr[BS_W-1:0];
      q  = {q[BYTES_W-2:0], ge};
    end
    q_step = q;
    r_step = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvs  <= divisor;
        quo  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        quo <= q_step;
        rem <= r_step;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: src/ibalc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibalc_dp: allocator datapath
// Config registers, LFSR, free-block bitmap, allocation slots, file table
// memory, counters and the output register.
// ----------------------------------------------------------------------------
module ibalc_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [ibalc_pkg::BS_W-1:0]    cfg_data,
  input  wire logic [ibalc_pkg::KEY_W-1:0]   file_key,
  input  wire logic [ibalc_pkg::BYTES_W-1:0] file_bytes,
  input  wire ibalc_pkg::ctrl_cmd_t          cmd_bus,
  output ibalc_pkg::dp_stat_t                stat,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         status,
  output logic [7:0]                         block_number,
  output logic                               is_index,
  output logic                               last
);
  import ibalc_pkg::*;

  logic [TB_W-1:0]    blk_span;
  logic [BS_W-1:0]    blk_bytes;
  logic [KEY_W-1:0]   req_key;
  logic [BYTES_W-1:0] req_bytes;
  logic [15:0]        lfsr;
  logic [15:0]        lfsr_next;
  logic [TB_W-1:0]    n_eff;
  logic [BS_W-1:0]    bs_eff;
  logic [TB_W-1:0]    probe_cnt;
  logic [CNT_W-1:0]   need;
  logic [SLOT_W-1:0]  alloc_cnt;
  logic [SLOT_W-1:0]  j;
  logic [SLOT_W-1:0]  jm1;
  logic [FT_W-1:0]    file_total;
  logic [FT_W-1:0]    ptr;
  logic [FT_W-1:0]    ptr_plus;
  logic [MAX_BLOCKS-1:0] bitmap;
  blk_t               alloc [SLOTS];
  tbl_row_t           mem [FILE_SLOTS];
  tbl_row_t           rdata;
  tbl_row_t           new_row;
  logic [CNT_W-1:0]   cnt_eff;
  blk_t               free_blk;
  blk_t               pos;

  logic               div_start;
  logic               div_done;
  logic [BYTES_W-1:0] div_dividend;
  logic [BS_W-1:0]    div_divisor;
  logic [BYTES_W-1:0] div_quo;
  logic [BS_W-1:0]    div_rem;
  logic               rem_nz;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  tbl_row_t           wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;

  always_comb begin
    lfsr_next = {1'b0, lfsr[15:1]};
    if (lfsr[0]) lfsr_next = lfsr_next ^ LFSR_TAPS;
  end

  always_comb begin
    if (blk_span == '0)                      n_eff = TB_W'(1);
    else if (blk_span > TB_W'(MAX_BLOCKS))   n_eff = TB_W'(MAX_BLOCKS);
    else                                     n_eff = blk_span;
  end

  assign bs_eff       = (blk_bytes == '0) ? BS_W'(1) : blk_bytes;
  assign div_start    = cmd_bus.div_size | cmd_bus.div_probe;
  assign div_dividend = cmd_bus.div_probe ? BYTES_W'(lfsr_next) : req_bytes;
  assign div_divisor  = cmd_bus.div_probe ? BS_W'(n_eff) : bs_eff;

  ibalc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign rem_nz   = (div_rem != '0);
  assign pos      = div_rem[BLK_W-1:0];
  assign jm1      = j - 1'b1;
  assign ptr_plus = ptr + 1'b1;
  assign cnt_eff  = (rdata.count > CNT_W'(BLOCKS_PER_FILE)) ?
                    CNT_W'(BLOCKS_PER_FILE) : rdata.count;
  assign free_blk = (j == '0) ? rdata.idx_blk : rdata.data[jm1[CNT_W-1:0]];

  always_comb begin
    new_row.key     = req_key;
    new_row.idx_blk = alloc[0];
    new_row.count   = need;
    for (int i = 0; i < BLOCKS_PER_FILE; i++) new_row.data[i] = alloc[i+1];
  end

  always_comb begin
    stat.div_done    = div_done;
    stat.too_large   = (div_quo > BYTES_W'(BLOCKS_PER_FILE)) ||
                       ((div_quo == BYTES_W'(BLOCKS_PER_FILE)) && rem_nz);
    stat.table_full  = (file_total >= FT_W'(FILE_SLOTS));
    stat.ft_zero     = (file_total == '0);
    stat.pos_free    = !bitmap[pos];
    stat.probe_last  = ({1'b0, probe_cnt} + 1'b1) == {1'b0, n_eff};
    stat.alloc_done  = (alloc_cnt == SLOT_W'(need));
    stat.alloc_empty = (alloc_cnt == '0);
    stat.rb_done     = ({1'b0, j} + 1'b1) == {1'b0, alloc_cnt};
    stat.key_match   = (rdata.key == req_key);
    stat.search_last = ({1'b0, ptr} + 1'b1) >= {1'b0, file_total};
    stat.dfree_done  = (j == SLOT_W'(cnt_eff));
    stat.shift_done  = ({1'b0, ptr} + 1'b1) >= {1'b0, file_total};
    stat.emit_last   = (j == SLOT_W'(need));
    stat.out_free    = !out_valid || !out_stall;
  end

  // Config, LFSR, bitmap and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_span     <= TB_RESET;
      blk_bytes    <= BS_RESET;
      lfsr         <= LFSR_SEED;
      bitmap       <= '0;
      file_total   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BLK_SPAN:  blk_span  <= cfg_data[TB_W-1:0];
          REG_BLK_BYTES: blk_bytes <= cfg_data;
          default:       blk_bytes <= cfg_data;
        endcase
      end
      if (cmd_bus.div_probe) lfsr <= lfsr_next;
      if (cmd_bus.take)      bitmap[pos] <= 1'b1;
      if (cmd_bus.rb_free)   bitmap[alloc[j[SLOT_W-1:0]]] <= 1'b0;
      if (cmd_bus.del_free)  bitmap[free_blk] <= 1'b0;
      if (cmd_bus.tbl_new)       file_total <= file_total + 1'b1;
      else if (cmd_bus.ft_dec)   file_total <= file_total - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_bus.load_req) begin
      req_key   <= file_key;
      req_bytes <= file_bytes;
    end
    if (cmd_bus.need_load) need <= div_quo[CNT_W-1:0] + CNT_W'(rem_nz);
    if (cmd_bus.probe_clr)      probe_cnt <= '0;
    else if (cmd_bus.probe_inc) probe_cnt <= probe_cnt + 1'b1;
    if (cmd_bus.alloc_clr) alloc_cnt <= '0;
    else if (cmd_bus.take) begin
      alloc[alloc_cnt] <= pos;
      alloc_cnt        <= alloc_cnt + 1'b1;
    end
    if (cmd_bus.j_clr)      j <= '0;
    else if (cmd_bus.j_inc) j <= j + 1'b1;
    if (cmd_bus.ptr_clr)      ptr <= '0;
    else if (cmd_bus.ptr_inc) ptr <= ptr_plus;
  end

  // File table memory: one write port, one registered read port.
  assign wr_en   = cmd_bus.tbl_new | cmd_bus.wr_shift;
  assign wr_addr = cmd_bus.tbl_new ? file_total[ADDR_W-1:0] : ptr[ADDR_W-1:0];
  assign wr_data = cmd_bus.tbl_new ? new_row : rdata;
  assign rd_en   = cmd_bus.rd_ptr | cmd_bus.rd_next;
  assign rd_addr = cmd_bus.rd_next ? ptr_plus[ADDR_W-1:0] : ptr[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_bus.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_bus.emit) begin
      status       <= cmd_bus.emit_grant ? ST_GRANT : cmd_bus.emit_code;
      block_number <= cmd_bus.emit_grant ? 8'(alloc[j]) : 8'd0;
      is_index     <= cmd_bus.emit_grant && (j == '0);
      last         <= cmd_bus.emit_grant ? stat.emit_last : 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: src/ibalc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibalc_ctrl: allocator controller
// Sequences sizing, probing, rollback, table update, delete search and
// shift, and result transfers.
// ----------------------------------------------------------------------------
module ibalc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_accept,
  input  wire logic                 in_cmd,
  input  wire ibalc_pkg::dp_stat_t  stat,
  output ibalc_pkg::ctrl_cmd_t      cmd_bus,
  output logic                      busy
);
  import ibalc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SIZE_GO, S_SIZE_WAIT, S_PROBE_GO, S_PROBE_WAIT, S_ROLLBACK,
    S_TBL_WR, S_GRANT, S_REPLY, S_DEL_START, S_DEL_RD, S_DEL_CMP,
    S_DEL_FREE, S_SH_CHECK, S_SH_RD, S_SH_WR
  } state_t;

  state_t     state, state_next;
  logic [2:0] code, code_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd_bus    = '0;
    state_next = state;
    code_next  = code;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          cmd_bus.load_req = 1'b1;
          state_next = (in_cmd == CMD_DELETE) ? S_DEL_START : S_SIZE_GO;
        end
      end
      S_SIZE_GO: begin
        cmd_bus.div_size = 1'b1;
        state_next = S_SIZE_WAIT;
      end
      S_SIZE_WAIT: begin
        if (stat.div_done) begin
          cmd_bus.need_load = 1'b1;
          priority if (stat.too_large) begin
            code_next  = ST_TOO_LARGE;
            state_next = S_REPLY;
          end else if (stat.table_full) begin
            code_next  = ST_TABLE_FULL;
            state_next = S_REPLY;
          end else begin
            cmd_bus.alloc_clr = 1'b1;
            cmd_bus.probe_clr = 1'b1;
            state_next = S_PROBE_GO;
          end
        end
      end
      S_PROBE_GO: begin
        cmd_bus.div_probe = 1'b1;
        state_next = S_PROBE_WAIT;
      end
      S_PROBE_WAIT: begin
        if (stat.div_done) begin
          priority if (stat.pos_free) begin
            cmd_bus.take = 1'b1;
            if (stat.alloc_done) begin
              state_next = S_TBL_WR;
            end else begin
              cmd_bus.probe_clr = 1'b1;
              state_next = S_PROBE_GO;
            end
          end else if (stat.probe_last) begin
            if (stat.alloc_empty) begin
              code_next  = ST_NO_INDEX;
              state_next = S_REPLY;
            end else begin
              cmd_bus.j_clr = 1'b1;
              state_next = S_ROLLBACK;
            end
          end else begin
            cmd_bus.probe_inc = 1'b1;
            state_next = S_PROBE_GO;
          end
        end
      end
      S_ROLLBACK: begin
        cmd_bus.rb_free = 1'b1;
        cmd_bus.j_inc   = 1'b1;
        if (stat.rb_done) begin
          code_next  = ST_MEM_FULL;
          state_next = S_REPLY;
        end
      end
      S_TBL_WR: begin
        cmd_bus.tbl_new = 1'b1;
        cmd_bus.j_clr   = 1'b1;
        state_next = S_GRANT;
      end
      S_GRANT: begin
        if (stat.out_free) begin
          cmd_bus.emit       = 1'b1;
          cmd_bus.emit_grant = 1'b1;
          cmd_bus.j_inc      = 1'b1;
          if (stat.emit_last) state_next = S_IDLE;
        end
      end
      S_REPLY: begin
        if (stat.out_free) begin
          cmd_bus.emit      = 1'b1;
          cmd_bus.emit_code = code;
          state_next = S_IDLE;
        end
      end
      S_DEL_START: begin
        cmd_bus.ptr_clr = 1'b1;
        if (stat.ft_zero) begin
          code_next  = ST_NOT_FOUND;
          state_next = S_REPLY;
        end else begin
          state_next = S_DEL_RD;
        end
      end
      S_DEL_RD: begin
        cmd_bus.rd_ptr = 1'b1;
        state_next = S_DEL_CMP;
      end
      S_DEL_CMP: begin
        priority if (stat.key_match) begin
          cmd_bus.j_clr = 1'b1;
          state_next = S_DEL_FREE;
        end else if (stat.search_last) begin
          code_next  = ST_NOT_FOUND;
          state_next = S_REPLY;
        end else begin
          cmd_bus.ptr_inc = 1'b1;
          state_next = S_DEL_RD;
        end
      end
      S_DEL_FREE: begin
        cmd_bus.del_free = 1'b1;
        cmd_bus.j_inc    = 1'b1;
        if (stat.dfree_done) state_next = S_SH_CHECK;
      end
      S_SH_CHECK: begin
        if (stat.shift_done) begin
          cmd_bus.ft_dec = 1'b1;
          code_next  = ST_DELETED;
          state_next = S_REPLY;
        end else begin
          state_next = S_SH_RD;
        end
      end
      S_SH_RD: begin
        cmd_bus.rd_next = 1'b1;
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_bus.wr_shift = 1'b1;
        cmd_bus.ptr_inc  = 1'b1;
        state_next = S_SH_CHECK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_GRANT;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

endmodule
`default_nettype wire

// File: src/indexed_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_block_allocator: file block allocator with free-block bitmap
// Creates files by probing a bitmap at LFSR positions for an index block and
// data blocks, deletes files by key from a compacted file table.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       to block   in_valid / in_stall   cmd, file_key, file_bytes
//  out      from block out_valid / out_stall status, block_number, is_index, last
//  cfg      to block   cfg_we                cfg_index, cfg_data
//
// One request at a time; in_stall is high from the transfer until the last result
// is loaded, so the next request may transfer while that result still waits.
// Create: sizing, then probes (launch, divider run, bitmap test), rollback of each
// taken block on failure, a table write, then one result per granted block.
// Delete: search of the entries, freeing of the file's blocks, shift of later entries.
// rst clears bitmap and file count and reseeds the LFSR; output stalls hold the result state.
// ----------------------------------------------------------------------------
module indexed_block_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          cmd,
  input  wire logic [ibalc_pkg::KEY_W-1:0]   file_key,
  input  wire logic [ibalc_pkg::BYTES_W-1:0] file_bytes,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         status,
  output logic [7:0]                         block_number,
  output logic                               is_index,
  output logic                               last,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [ibalc_pkg::BS_W-1:0]    cfg_data
);
  import ibalc_pkg::*;

  ctrl_cmd_t cmd_bus;
  dp_stat_t  stat;
  logic      busy;
  logic      in_accept;

  // Take a request only while the controller is idle.
  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;

  ibalc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_cmd    (cmd),
    .stat      (stat),
    .cmd_bus   (cmd_bus),
    .busy      (busy)
  );

  ibalc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .file_key     (file_key),
    .file_bytes   (file_bytes),
    .cmd_bus      (cmd_bus),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .block_number (block_number),
    .is_index     (is_index),
    .last         (last)
  );

endmodule
`default_nettype wire

// File: src/ibalc_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibalc_chk: port checker for the allocator
// Watches the request and result channels at the top level ports.
// ----------------------------------------------------------------------------
module ibalc_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] status,
  input wire logic [7:0] block_number,
  input wire logic       is_index,
  input wire logic       last
);
  import ibalc_pkg::*;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request transfer did not make the block busy");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
    $stable(block_number) && $stable(last))
    else $error("stalled result changed");

  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_GRANT |-> last)
    else $error("non-grant result not marked last");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_GRANT |-> block_number == 8'd0 && !is_index)
    else $error("non-grant result carries a block");

endmodule

bind indexed_block_allocator ibalc_chk u_chk (.*);
`default_nettype wire
